[hw/rtl/register_pool_with_spill_slots_macros.svh]
// ----------------------------------------------------------------------------
// register pool with spill slots: assertion macros
// concurrent checks sampled on the rising clock, off while reset is low
// ----------------------------------------------------------------------------
`ifndef REGISTER_POOL_WITH_SPILL_SLOTS_MACROS_SVH
`define REGISTER_POOL_WITH_SPILL_SLOTS_MACROS_SVH

// same-cycle implication
`define RPSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rpss_pkg.sv]
// ----------------------------------------------------------------------------
// rpss_pkg
// request, result and internal command types for the register pool
// ----------------------------------------------------------------------------
package rpss_pkg;

	localparam logic [1:0] REQ_ALLOC    = 2'd0;
	localparam logic [1:0] REQ_REL_REG  = 2'd1;
	localparam logic [1:0] REQ_REL_SLOT = 2'd2;
	localparam logic [1:0] REQ_SET      = 2'd3;

	localparam logic [1:0] CLS_CORE  = 2'd0;
	localparam logic [1:0] CLS_FLOAT = 2'd1;
	localparam logic [1:0] CLS_SPILL = 2'd2;

	localparam int unsigned CORE_BASE  = 4;
	localparam int unsigned FLOAT_BASE = 16;

	localparam int unsigned REG_AW = 6;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] reg_class;
		logic [4:0] reg_number;
		logic [8:0] slot_or_count;
	} rpss_req_t;

	typedef struct packed {
		logic       got_spill;
		logic [4:0] alloc_reg;
		logic [7:0] alloc_slot;
		logic [4:0] core_high_water;
		logic [5:0] float_high_water;
		logic [8:0] spill_count;
		logic       status;
	} rpss_rsp_t;

	// register memory port: float at 0..31, core at 32..47
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [REG_AW-1:0] addr;
		logic [4:0]        wdata;
	} rpss_rmem_cmd_t;

	typedef struct packed {
		logic       done;
		logic       pop_reg;
		logic       pop_slot;
		logic       mint;
		logic [7:0] mint_slot;
		logic       status;
		logic [4:0] core_used;
		logic [5:0] float_used;
		logic [8:0] minted;
	} rpss_stat_t;

endpackage

[hw/rtl/rpss_reg_mem.sv]
// ----------------------------------------------------------------------------
// rpss_reg_mem
// core and float free stacks in one memory, registered read, per-entry
// valid bits so unwritten entries read as their initial register number
// ----------------------------------------------------------------------------
module rpss_reg_mem
	import rpss_pkg::*;
#(
	parameter int CORE_POOL  = 8,
	parameter int FLOAT_POOL = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rpss_rmem_cmd_t cmd,
	output logic [4:0]     rdata
);

	localparam int DEPTH = 48;

	logic [4:0]       mem [0:DEPTH-1];
	logic [DEPTH-1:0] vld_q;
	logic [4:0]       rdata_s1;
	logic [4:0]       init_s1;
	logic             vld_s1;

	function automatic logic [4:0] init_val(input logic [REG_AW-1:0] a);
		logic [31:0] idx;
		logic [31:0] v;
		begin
			v = '0;
			if (a[REG_AW-1]) begin
				idx = 32'(a[3:0]);
				if (idx < 32'(CORE_POOL))
					v = 32'(CORE_BASE) + 32'(CORE_POOL) - 32'd1 - idx;
			end else begin
				idx = 32'(a[4:0]);
				if (idx < 32'(FLOAT_POOL))
					v = 32'(FLOAT_BASE) + 32'(FLOAT_POOL) - 32'd1 - idx;
			end
			return v[4:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[cmd.addr] <= cmd.wdata;
		if (cmd.rd_en) begin
			rdata_s1 <= mem[cmd.addr];
			init_s1  <= init_val(cmd.addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.wr_en)
				vld_q[cmd.addr] <= 1'b1;
			if (cmd.rd_en)
				vld_s1 <= vld_q[cmd.addr];
		end
	end

	assign rdata = vld_s1 ? rdata_s1 : init_s1;

endmodule

[hw/rtl/rpss_slot_mem.sv]
// ----------------------------------------------------------------------------
// rpss_slot_mem
// freed spill slot stack, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module rpss_slot_mem #(
	parameter int SPILL_SLOTS = 256,
	localparam int SAW = $clog2(SPILL_SLOTS)
) (
	input  logic           clk,
	input  logic           rd_en,
	input  logic           wr_en,
	input  logic [SAW-1:0] addr,
	input  logic [7:0]     wdata,
	output logic [7:0]     rdata
);

	logic [7:0] mem [0:SPILL_SLOTS-1];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= wdata;
		if (rd_en)
			rdata <= mem[addr];
	end

endmodule

[hw/rtl/rpss_ctrl.sv]
// ----------------------------------------------------------------------------
// rpss_ctrl
// request decode, stack pointers, high-water and spill counters
// ----------------------------------------------------------------------------
`include "register_pool_with_spill_slots_macros.svh"

module rpss_ctrl
	import rpss_pkg::*;
#(
	parameter int CORE_POOL   = 8,
	parameter int FLOAT_POOL  = 16,
	parameter int SPILL_SLOTS = 256,
	localparam int SAW = $clog2(SPILL_SLOTS),
	localparam int STW = $clog2(SPILL_SLOTS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rpss_req_t      req,
	output rpss_rmem_cmd_t rcmd,
	output logic           slot_rd_en,
	output logic           slot_wr_en,
	output logic [SAW-1:0] slot_addr,
	output logic [7:0]     slot_wdata,
	output rpss_stat_t     stat
);

	localparam logic [5:0]  CORE_POOL_W  = 6'(CORE_POOL);
	localparam logic [6:0]  FLOAT_POOL_W = 7'(FLOAT_POOL);
	localparam logic [31:0] SLOTS_W      = 32'(SPILL_SLOTS);

	logic [4:0]     core_top_q, core_top_d, core_dec;
	logic [5:0]     float_top_q, float_top_d, float_dec;
	logic [STW-1:0] slot_top_q, slot_top_d, slot_dec;
	logic [4:0]     core_used_q, core_used_d, core_hw;
	logic [5:0]     float_used_q, float_used_d, float_hw;
	logic [8:0]     minted_q, minted_d;
	logic [5:0]     core_now;
	logic [6:0]     float_now;
	logic           mint_ok, slot_rel_ok, slot_room;
	logic           pop_reg, pop_slot, mint, status;
	logic           done_s1, pop_reg_s1, pop_slot_s1, mint_s1, status_s1;
	logic [7:0]     mint_slot_s1;

	assign core_dec  = core_top_q - 5'd1;
	assign float_dec = float_top_q - 6'd1;
	assign slot_dec  = slot_top_q - STW'(1);

	assign core_now  = (CORE_POOL_W > {1'b0, core_dec}) ? CORE_POOL_W - {1'b0, core_dec} : '0;
	assign core_hw   = (core_now > {1'b0, core_used_q}) ? core_now[4:0] : core_used_q;
	assign float_now = (FLOAT_POOL_W > {1'b0, float_dec}) ?
		FLOAT_POOL_W - {1'b0, float_dec} : '0;
	assign float_hw  = (float_now > {1'b0, float_used_q}) ? float_now[5:0] : float_used_q;

	assign mint_ok     = 32'(minted_q) < SLOTS_W;
	assign slot_rel_ok = (32'(req.slot_or_count) < SLOTS_W) && !req.slot_or_count[8];
	assign slot_room   = 32'(slot_top_q) < SLOTS_W;

	always_comb begin
		core_top_d   = core_top_q;
		float_top_d  = float_top_q;
		slot_top_d   = slot_top_q;
		core_used_d  = core_used_q;
		float_used_d = float_used_q;
		minted_d     = minted_q;
		rcmd         = '0;
		slot_rd_en   = 1'b0;
		slot_wr_en   = 1'b0;
		slot_addr    = '0;
		slot_wdata   = req.slot_or_count[7:0];
		pop_reg      = 1'b0;
		pop_slot     = 1'b0;
		mint         = 1'b0;
		status       = 1'b0;
		if (start) begin
			unique case (req.req_type)
				REQ_ALLOC: begin
					if (req.reg_class == CLS_CORE && core_top_q != '0) begin
						core_top_d  = core_dec;
						core_used_d = core_hw;
						rcmd.rd_en  = 1'b1;
						rcmd.addr   = {2'b10, core_dec[3:0]};
						pop_reg     = 1'b1;
					end else if (req.reg_class == CLS_FLOAT && float_top_q != '0) begin
						float_top_d  = float_dec;
						float_used_d = float_hw;
						rcmd.rd_en   = 1'b1;
						rcmd.addr    = {1'b0, float_dec[4:0]};
						pop_reg      = 1'b1;
					end else if (req.reg_class == CLS_CORE || req.reg_class == CLS_FLOAT) begin
						if (slot_top_q != '0) begin
							slot_top_d = slot_dec;
							slot_rd_en = 1'b1;
							slot_addr  = slot_dec[SAW-1:0];
							pop_slot   = 1'b1;
						end else if (mint_ok) begin
							minted_d = 9'(minted_q + 9'd1);
							mint     = 1'b1;
						end else begin
							status = 1'b1;
						end
					end
				end
				REQ_REL_REG: begin
					if (req.reg_class == CLS_CORE && !req.reg_number[4]) begin
						if (!core_top_q[4]) begin
							rcmd.wr_en = 1'b1;
							rcmd.addr  = {2'b10, core_top_q[3:0]};
							rcmd.wdata = req.reg_number;
							core_top_d = core_top_q + 5'd1;
						end else begin
							status = 1'b1;
						end
					end else if (req.reg_class == CLS_FLOAT) begin
						if (!float_top_q[5]) begin
							rcmd.wr_en  = 1'b1;
							rcmd.addr   = {1'b0, float_top_q[4:0]};
							rcmd.wdata  = req.reg_number;
							float_top_d = float_top_q + 6'd1;
						end else begin
							status = 1'b1;
						end
					end
				end
				REQ_REL_SLOT: begin
					if (slot_rel_ok) begin
						if (slot_room) begin
							slot_wr_en = 1'b1;
							slot_addr  = slot_top_q[SAW-1:0];
							slot_top_d = slot_top_q + STW'(1);
						end else begin
							status = 1'b1;
						end
					end
				end
				REQ_SET: begin
					if (req.reg_class == CLS_CORE)
						core_used_d = req.slot_or_count[4:0];
					else if (req.reg_class == CLS_FLOAT)
						float_used_d = req.slot_or_count[5:0];
					else if (req.reg_class == CLS_SPILL)
						minted_d = req.slot_or_count;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_top_q   <= 5'(CORE_POOL);
			float_top_q  <= 6'(FLOAT_POOL);
			slot_top_q   <= '0;
			core_used_q  <= '0;
			float_used_q <= '0;
			minted_q     <= '0;
			done_s1      <= 1'b0;
			pop_reg_s1   <= 1'b0;
			pop_slot_s1  <= 1'b0;
			mint_s1      <= 1'b0;
			status_s1    <= 1'b0;
		end else begin
			core_top_q   <= core_top_d;
			float_top_q  <= float_top_d;
			slot_top_q   <= slot_top_d;
			core_used_q  <= core_used_d;
			float_used_q <= float_used_d;
			minted_q     <= minted_d;
			done_s1      <= start;
			pop_reg_s1   <= pop_reg;
			pop_slot_s1  <= pop_slot;
			mint_s1      <= mint;
			status_s1    <= status;
		end
	end

	always_ff @(posedge clk) begin
		if (mint)
			mint_slot_s1 <= minted_q[7:0];
	end

	always_comb begin
		stat.done       = done_s1;
		stat.pop_reg    = pop_reg_s1;
		stat.pop_slot   = pop_slot_s1;
		stat.mint       = mint_s1;
		stat.mint_slot  = mint_slot_s1;
		stat.status     = status_s1;
		stat.core_used  = core_used_q;
		stat.float_used = float_used_q;
		stat.minted     = minted_q;
	end

	`RPSS_ASSERT_NEXT(a_done_follows_start, clk, arst_n, start, done_s1, "transfer without result")
	`RPSS_ASSERT_NEXT(a_no_spurious_done, clk, arst_n, !start, !done_s1, "result without transfer")
	`RPSS_ASSERT_NOW(a_core_top_range, clk, arst_n, 1'b1, core_top_q <= 5'd16, "core top overflow")
	`RPSS_ASSERT_NOW(a_float_top_range, clk, arst_n, 1'b1, float_top_q <= 6'd32, "float top overflow")
	`RPSS_ASSERT_NEXT(a_mint_count, clk, arst_n, mint, minted_q == 9'($past(minted_q) + 9'd1), "mint count")
	`RPSS_ASSERT_NOW(a_one_result_kind, clk, arst_n, done_s1, $onehot0({pop_reg_s1, pop_slot_s1, mint_s1, status_s1}), "result kinds overlap")

endmodule

[hw/rtl/register_pool_with_spill_slots.sv]
// ----------------------------------------------------------------------------
// register_pool_with_spill_slots
// core and float register free pools backed by a shared spill slot pool
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low; busy
//   stays low, so a request may be issued every cycle
//   the result appears in the cycle after the transfer, marked by done, and is
//   valid for exactly one cycle; the receiver cannot hold it off
//   throughput is one request per cycle: pointers and counters update at the
//   transfer edge and the stack memories are read or written there, so the
//   registered read data of a pop is ready in the result cycle
//   every result carries both high-water counts and the spill count as they
//   stand after that request
//   reset returns the core pool to registers 4 and up and the float pool to
//   registers 16 and up, clears all counts and empties the freed slot stack;
//   register entries carry valid bits, so no clearing pass is needed and
//   requests are taken from the first cycle after reset
// ----------------------------------------------------------------------------
module register_pool_with_spill_slots
	import rpss_pkg::*;
#(
	parameter int CORE_POOL   = 8,
	parameter int FLOAT_POOL  = 16,
	parameter int SPILL_SLOTS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  rpss_req_t req,
	output logic      done,
	output rpss_rsp_t rsp
);

	localparam int SAW = $clog2(SPILL_SLOTS);

	rpss_rmem_cmd_t rcmd;
	rpss_stat_t     stat;
	logic [4:0]     reg_rdata;
	logic           slot_rd_en, slot_wr_en;
	logic [SAW-1:0] slot_addr;
	logic [7:0]     slot_wdata, slot_rdata;

	rpss_ctrl #(
		.CORE_POOL   (CORE_POOL),
		.FLOAT_POOL  (FLOAT_POOL),
		.SPILL_SLOTS (SPILL_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.rcmd       (rcmd),
		.slot_rd_en (slot_rd_en),
		.slot_wr_en (slot_wr_en),
		.slot_addr  (slot_addr),
		.slot_wdata (slot_wdata),
		.stat       (stat)
	);

	rpss_reg_mem #(
		.CORE_POOL  (CORE_POOL),
		.FLOAT_POOL (FLOAT_POOL)
	) u_reg_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rcmd),
		.rdata  (reg_rdata)
	);

	rpss_slot_mem #(
		.SPILL_SLOTS (SPILL_SLOTS)
	) u_slot_mem (
		.clk   (clk),
		.rd_en (slot_rd_en),
		.wr_en (slot_wr_en),
		.addr  (slot_addr),
		.wdata (slot_wdata),
		.rdata (slot_rdata)
	);

	assign busy = 1'b0;
	assign done = stat.done;

	always_comb begin
		rsp.got_spill        = stat.pop_slot | stat.mint;
		rsp.alloc_reg        = stat.pop_reg ? reg_rdata : '0;
		rsp.alloc_slot       = stat.pop_slot ? slot_rdata :
			(stat.mint ? stat.mint_slot : '0);
		rsp.core_high_water  = stat.core_used;
		rsp.float_high_water = stat.float_used;
		rsp.spill_count      = stat.minted;
		rsp.status           = stat.status;
	end

endmodule

[tb/sv/register_pool_with_spill_slots_tb.sv]
// ----------------------------------------------------------------------------
// register_pool_with_spill_slots_tb
// drives allocate, release and set-count requests into the register pool and
// checks every result against a cycle-free model of the core, float and
// spill-slot stacks; directed edge cases first, then random traffic
// ----------------------------------------------------------------------------
module register_pool_with_spill_slots_tb
	import rpss_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CORE_POOL   = 8;
	localparam int unsigned FLOAT_POOL  = 16;
	localparam int unsigned SPILL_SLOTS = 256;
	localparam int unsigned CORE_DEPTH  = 16;
	localparam int unsigned FLOAT_DEPTH = 32;
	localparam int unsigned RUN_LIMIT   = 200000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	rpss_req_t req;
	logic      done;
	rpss_rsp_t rsp;

	// model of the pools
	logic [4:0]  core_pool [CORE_DEPTH];
	logic [4:0]  float_pool [FLOAT_DEPTH];
	logic [7:0]  slot_pool [SPILL_SLOTS];
	int unsigned core_sp;
	int unsigned float_sp;
	int unsigned slot_sp;
	logic [4:0]  core_hw;
	logic [5:0]  float_hw;
	logic [8:0]  minted;

	rpss_rsp_t   replies_due [$];
	rpss_rsp_t   oldest_reply;
	int unsigned fault_count;
	int unsigned requests_sent;
	int unsigned cycle_count;
	bit          steady_traffic;

	register_pool_with_spill_slots #(
		.CORE_POOL   (CORE_POOL),
		.FLOAT_POOL  (FLOAT_POOL),
		.SPILL_SLOTS (SPILL_SLOTS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("register_pool_with_spill_slots verification failed");
			$finish;
		end
	end

	function automatic rpss_req_t mk_req(logic [1:0] kind, logic [1:0] cls, logic [4:0] num,
			logic [8:0] val);
		rpss_req_t r;
		r.req_type      = kind;
		r.reg_class     = cls;
		r.reg_number    = num;
		r.slot_or_count = val;
		return r;
	endfunction

	function automatic void reset_pools();
		for (int i = 0; i < CORE_DEPTH; i++)
			core_pool[i] = (i < CORE_POOL) ? 5'(CORE_BASE + CORE_POOL - 1 - i) : 5'd0;
		for (int i = 0; i < FLOAT_DEPTH; i++)
			float_pool[i] = (i < FLOAT_POOL) ? 5'(FLOAT_BASE + FLOAT_POOL - 1 - i) : 5'd0;
		core_sp  = CORE_POOL;
		float_sp = FLOAT_POOL;
		slot_sp  = 0;
		core_hw  = '0;
		float_hw = '0;
		minted   = '0;
	endfunction

	// applies one request to the pools and returns the result it produces
	function automatic rpss_rsp_t pool_reply(rpss_req_t r);
		rpss_rsp_t   o;
		int unsigned in_use;
		o = '0;
		case (r.req_type)
			REQ_ALLOC: begin
				if (r.reg_class == CLS_CORE && core_sp > 0) begin
					core_sp--;
					o.alloc_reg = core_pool[core_sp];
					in_use = (CORE_POOL > core_sp) ? CORE_POOL - core_sp : 0;
					if (in_use > core_hw)
						core_hw = in_use[4:0];
				end else if (r.reg_class == CLS_FLOAT && float_sp > 0) begin
					float_sp--;
					o.alloc_reg = float_pool[float_sp];
					in_use = (FLOAT_POOL > float_sp) ? FLOAT_POOL - float_sp : 0;
					if (in_use > float_hw)
						float_hw = in_use[5:0];
				end else if (r.reg_class == CLS_CORE || r.reg_class == CLS_FLOAT) begin
					if (slot_sp > 0) begin
						slot_sp--;
						o.alloc_slot = slot_pool[slot_sp];
						o.got_spill  = 1'b1;
					end else if (minted < SPILL_SLOTS) begin
						o.alloc_slot = minted[7:0];
						o.got_spill  = 1'b1;
						minted       = minted + 9'd1;
					end else begin
						o.status = 1'b1;
					end
				end
			end
			REQ_REL_REG: begin
				if (r.reg_class == CLS_CORE && r.reg_number < CORE_DEPTH) begin
					if (core_sp < CORE_DEPTH) begin
						core_pool[core_sp] = r.reg_number;
						core_sp++;
					end else begin
						o.status = 1'b1;
					end
				end else if (r.reg_class == CLS_FLOAT) begin
					if (float_sp < FLOAT_DEPTH) begin
						float_pool[float_sp] = r.reg_number;
						float_sp++;
					end else begin
						o.status = 1'b1;
					end
				end
			end
			REQ_REL_SLOT: begin
				if (r.slot_or_count < SPILL_SLOTS && r.slot_or_count <= 255) begin
					if (slot_sp < SPILL_SLOTS) begin
						slot_pool[slot_sp] = r.slot_or_count[7:0];
						slot_sp++;
					end else begin
						o.status = 1'b1;
					end
				end
			end
			REQ_SET: begin
				if (r.reg_class == CLS_CORE)
					core_hw = r.slot_or_count[4:0];
				else if (r.reg_class == CLS_FLOAT)
					float_hw = r.slot_or_count[5:0];
				else if (r.reg_class == CLS_SPILL)
					minted = r.slot_or_count;
			end
		endcase
		o.core_high_water  = core_hw;
		o.float_high_water = float_hw;
		o.spill_count      = minted;
		return o;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (replies_due.size() == 0) begin
				$error("result transfer with no request pending");
				fault_count++;
			end else begin
				oldest_reply = replies_due.pop_front();
				check_field("got_spill", oldest_reply.got_spill, rsp.got_spill);
				check_field("alloc_reg", oldest_reply.alloc_reg, rsp.alloc_reg);
				check_field("alloc_slot", oldest_reply.alloc_slot, rsp.alloc_slot);
				check_field("core_high_water", oldest_reply.core_high_water,
					rsp.core_high_water);
				check_field("float_high_water", oldest_reply.float_high_water,
					rsp.float_high_water);
				check_field("spill_count", oldest_reply.spill_count, rsp.spill_count);
				check_field("status", oldest_reply.status, rsp.status);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady_traffic)
			return 0;
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_req(rpss_req_t r);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		req   = r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		replies_due.insert(replies_due.size(), pool_reply(r));
		requests_sent++;
	endtask

	task automatic wait_for_replies();
		@(negedge clk);
		start = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// empty the core pool, then mint, hit the mint limit and reuse a freed slot
	task automatic test_pool_edges();
		steady_traffic = 1'b1;
		repeat (CORE_POOL)
			send_req(mk_req(REQ_ALLOC, CLS_CORE, 5'd0, 9'd0));
		send_req(mk_req(REQ_ALLOC, CLS_CORE, 5'd31, 9'd511));
		send_req(mk_req(REQ_SET, CLS_SPILL, 5'd0, 9'd256));
		send_req(mk_req(REQ_ALLOC, CLS_CORE, 5'd0, 9'd0));
		send_req(mk_req(REQ_SET, CLS_SPILL, 5'd0, 9'd255));
		send_req(mk_req(REQ_ALLOC, CLS_CORE, 5'd0, 9'd0));
		send_req(mk_req(REQ_ALLOC, CLS_CORE, 5'd0, 9'd0));
		send_req(mk_req(REQ_REL_SLOT, CLS_CORE, 5'd0, 9'd256));
		send_req(mk_req(REQ_REL_SLOT, CLS_CORE, 5'd0, 9'd255));
		send_req(mk_req(REQ_ALLOC, CLS_CORE, 5'd0, 9'd0));
		send_req(mk_req(REQ_ALLOC, CLS_FLOAT, 5'd0, 9'd0));
	endtask

	task automatic test_ignored_requests();
		steady_traffic = 1'b0;
		send_req(mk_req(REQ_REL_REG, CLS_CORE, 5'd20, 9'd0));
		send_req(mk_req(REQ_REL_REG, CLS_SPILL, 5'd5, 9'd0));
		send_req(mk_req(REQ_REL_REG, 2'd3, 5'd31, 9'd511));
		send_req(mk_req(REQ_ALLOC, CLS_SPILL, 5'd0, 9'd0));
		send_req(mk_req(REQ_ALLOC, 2'd3, 5'd0, 9'd0));
	endtask

	task automatic test_set_counts();
		send_req(mk_req(REQ_SET, 2'd3, 5'd0, 9'd511));
		send_req(mk_req(REQ_SET, CLS_CORE, 5'd0, 9'd511));
		send_req(mk_req(REQ_SET, CLS_FLOAT, 5'd0, 9'd511));
		send_req(mk_req(REQ_SET, CLS_CORE, 5'd0, 9'd0));
		send_req(mk_req(REQ_SET, CLS_FLOAT, 5'd0, 9'd0));
		send_req(mk_req(REQ_SET, CLS_SPILL, 5'd0, 9'd0));
	endtask

	// push both register stacks past full
	task automatic test_full_register_stacks();
		steady_traffic = 1'b0;
		while (core_sp < CORE_DEPTH)
			send_req(mk_req(REQ_REL_REG, CLS_CORE, 5'($urandom_range(0, 15)), 9'($urandom)));
		repeat (2)
			send_req(mk_req(REQ_REL_REG, CLS_CORE, 5'($urandom_range(0, 15)), 9'd0));
		while (float_sp < FLOAT_DEPTH)
			send_req(mk_req(REQ_REL_REG, CLS_FLOAT, 5'($urandom), 9'($urandom)));
		repeat (2)
			send_req(mk_req(REQ_REL_REG, CLS_FLOAT, 5'($urandom), 9'd0));
	endtask

	task automatic test_full_slot_stack();
		while (slot_sp < SPILL_SLOTS) begin
			steady_traffic = ($urandom_range(0, 15) == 0) ? ~steady_traffic : steady_traffic;
			send_req(mk_req(REQ_REL_SLOT, 2'($urandom), 5'($urandom), 9'($urandom_range(0, 255))));
		end
		repeat (3)
			send_req(mk_req(REQ_REL_SLOT, CLS_CORE, 5'd0, 9'($urandom_range(0, 255))));
		steady_traffic = 1'b0;
	endtask

	task automatic test_random_traffic(int unsigned target);
		int unsigned pick;
		int unsigned len;
		logic [1:0]  cls;
		logic [8:0]  val;
		while (requests_sent < target) begin
			pick           = $urandom_range(0, 99);
			len            = $urandom_range(1, 20);
			cls            = $urandom_range(0, 1) ? CLS_FLOAT : CLS_CORE;
			steady_traffic = ($urandom_range(0, 3) == 0);
			if (pick < 35) begin
				repeat (len)
					send_req(mk_req(REQ_ALLOC, cls, 5'($urandom), 9'($urandom)));
			end else if (pick < 65) begin
				repeat (len) begin
					if (cls == CLS_CORE && $urandom_range(0, 7) != 0)
						send_req(mk_req(REQ_REL_REG, cls, 5'($urandom_range(0, 15)),
							9'($urandom)));
					else
						send_req(mk_req(REQ_REL_REG, cls, 5'($urandom), 9'($urandom)));
				end
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 6)) begin
					val = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(256, 511))
						: 9'($urandom_range(0, 255));
					send_req(mk_req(REQ_REL_SLOT, 2'($urandom), 5'($urandom), val));
				end
			end else if (pick < 88) begin
				cls = 2'($urandom_range(0, 2));
				case ($urandom_range(0, 2))
					0: val = 9'($urandom_range(250, 262));
					1: val = 9'($urandom_range(0, 40));
					default: val = 9'($urandom);
				endcase
				send_req(mk_req(REQ_SET, cls, 5'($urandom), val));
			end else begin
				repeat ($urandom_range(1, 4))
					send_req(rpss_req_t'(18'($urandom)));
			end
		end
		steady_traffic = 1'b0;
	endtask

	task automatic test_noise(int unsigned count);
		repeat (count)
			send_req(rpss_req_t'(18'($urandom)));
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		req            = '0;
		fault_count    = 0;
		requests_sent  = 0;
		cycle_count    = 0;
		steady_traffic = 1'b0;
		reset_pools();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_pool_edges();
		test_ignored_requests();
		test_set_counts();
		wait_for_replies();
		test_full_register_stacks();
		test_full_slot_stack();
		wait_for_replies();
		test_random_traffic(410);
		test_noise(40);

		wait_for_replies();
		repeat (4) @(posedge clk);
		if (fault_count == 0 && replies_due.size() == 0)
			$display("register_pool_with_spill_slots verification clean");
		else
			$display("register_pool_with_spill_slots verification failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rpss_pkg.sv
hw/rtl/rpss_reg_mem.sv
hw/rtl/rpss_slot_mem.sv
hw/rtl/rpss_ctrl.sv
hw/rtl/register_pool_with_spill_slots.sv
tb/sv/register_pool_with_spill_slots_tb.sv
